FILE: rtl/gtup_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtup_pkg
// shared types and constants of the gamma table unpacker and packer
// ----------------------------------------------------------------------------
package gtup_pkg;

    localparam int LEVELS = 256;

    // input word command codes
    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_RUN    = 2'd2,
        CMD_FINISH = 2'd3
    } t_cmd;

    // output word kinds
    localparam logic KIND_PACKED = 1'b0;
    localparam logic KIND_FORMAT = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic start;   // begin a channel pass
        logic load;    // write one low-part byte
        logic arm;     // capture the run increment
        logic step;    // expand one level
        logic tail;    // at most one more level left in this run
        logic fmt;     // build and send the format word
    } t_dp_ctl;

    // datapath status back to the controller
    typedef struct packed {
        logic lc_done;   // level count reached the end of the curve
        logic out_full;  // output word still waiting
        logic pass1;     // current pass is the packing pass
    } t_dp_sts;

endpackage

FILE: rtl/gamma_table_unpack_and_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamma_table_unpack_and_pack
// run-length gamma curve unpacker with difference measuring and word packing
// ----------------------------------------------------------------------------
// Input words carry a command in tuser: start a channel pass, load one byte
// of 2-bit low parts into the 64-entry store, expand a run byte, or finish
// the pass. A run byte expands one level per clock; its length is 1 to 32
// levels, and a run longer than the levels still left before the end of the
// curve stops there. The store has one read port and its read is pipelined
// one level ahead, which sets this one-level-per-cycle pace. In the packing
// pass every odd level sends one word (up to 16 per run), and the expansion
// holds while an output word is not taken. A finish in the measuring pass
// sends one format word as soon as the output register is free. Levels past
// 255 are dropped. The store has no reset: bytes must be loaded before the
// levels that use them are expanded. The output register decouples the two
// sides, so a new input word is taken while the last result still waits
// downstream.
// ----------------------------------------------------------------------------
module gamma_table_unpack_and_pack (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // channel[1:0], pass_number[2], lsb_index[8:3],
                                     // data_byte[16:9], zero fill[23:17]
    input  logic [1:0]  i_s_tuser,   // cmd[1:0]
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // word[15:0], pair_index[22:16], zero fill[23]
    output logic        o_m_tuser,   // kind[0]
    output logic        o_m_tlast
);
    import gtup_pkg::*;

    t_dp_ctl     w_ctl;
    t_dp_sts     w_sts;
    t_cmd        w_cmd;
    logic [15:0] w_word;
    logic [6:0]  w_pair;

    assign w_cmd = t_cmd'(i_s_tuser);

    // sequencer: accepts words and paces the level steps
    gtup_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_cmd      (w_cmd),
        .i_len_m1   (i_s_tdata[13:9]),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    // level datapath, low-part store and output register
    gtup_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .o_sts         (w_sts),
        .i_channel     (i_s_tdata[1:0]),
        .i_pass_number (i_s_tdata[2]),
        .i_lsb_index   (i_s_tdata[8:3]),
        .i_data_byte   (i_s_tdata[16:9]),
        .i_m_tready    (i_m_tready),
        .o_kind        (o_m_tuser),
        .o_word        (w_word),
        .o_pair_index  (w_pair),
        .o_last        (o_m_tlast),
        .o_valid       (o_m_tvalid)
    );

    assign o_m_tdata = {1'b0, w_pair, w_word};

`ifndef NO_ASSERTIONS
    // a format word always closes its input and names pair zero
    a_fmt_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tlast && o_m_tdata[22:16] == 7'd0))
        else $error("format word with nonzero pair or without last");

    // a packing step never overwrites a word that still waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.step && w_sts.pass1) |-> !w_sts.out_full)
        else $error("packed word overwritten");

    // no level is expanded past the end of the curve
    a_lc_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.lc_done |-> !w_ctl.step)
        else $error("level step past the end of the curve");

    // no input word is taken while a run is being expanded
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.step |-> !o_s_tready)
        else $error("input accepted during run expansion");
`endif

endmodule

FILE: rtl/gtup_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtup_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module gtup_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/gtup_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtup_ctrl
// command sequencer: decodes input words and steps runs level by level
// ----------------------------------------------------------------------------
module gtup_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  gtup_pkg::t_cmd    i_cmd,
    input  logic [4:0]        i_len_m1,
    input  gtup_pkg::t_dp_sts i_sts,
    output gtup_pkg::t_dp_ctl o_ctl
);
    import gtup_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FMT
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_rem, n_rem;   // levels left in the run, 1 to 32
    logic       w_accept;
    logic       w_go;

    assign w_accept   = (r_state == ST_IDLE) && i_s_tvalid;
    assign o_s_tready = (r_state == ST_IDLE);

    // a packing step needs a free output slot
    assign w_go = !i_sts.lc_done && !(i_sts.pass1 && i_sts.out_full);

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        o_ctl   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_cmd)
                        CMD_START: o_ctl.start = 1'b1;
                        CMD_LOAD:  o_ctl.load  = 1'b1;
                        CMD_RUN: begin
                            o_ctl.arm = 1'b1;
                            n_rem     = {1'b0, i_len_m1} + 6'd1;
                            n_state   = ST_RUN;
                        end
                        CMD_FINISH: begin
                            if (!i_sts.pass1) begin
                                n_state = ST_FMT;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RUN: begin
                o_ctl.tail = (r_rem <= 6'd2);
                if (i_sts.lc_done) begin
                    n_state = ST_IDLE;
                end else if (w_go) begin
                    o_ctl.step = 1'b1;
                    n_rem      = r_rem - 6'd1;
                    if (r_rem == 6'd1) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FMT: begin
                if (!i_sts.out_full) begin
                    o_ctl.fmt = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rem   <= '0;
        end else begin
            r_state <= n_state;
            r_rem   <= n_rem;
        end
    end

endmodule

FILE: rtl/gtup_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtup_dp
// level expansion, difference measuring, packing and output register
// ----------------------------------------------------------------------------
module gtup_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gtup_pkg::t_dp_ctl i_ctl,
    output gtup_pkg::t_dp_sts o_sts,
    input  logic [1:0]        i_channel,
    input  logic              i_pass_number,
    input  logic [5:0]        i_lsb_index,
    input  logic [7:0]        i_data_byte,
    input  logic              i_m_tready,
    output logic              o_kind,
    output logic [15:0]       o_word,
    output logic [6:0]        o_pair_index,
    output logic              o_last,
    output logic              o_valid
);
    import gtup_pkg::*;

    localparam int LCW = $clog2(LEVELS) + 1;

    // group of a level pair: 0..2, 3 for none
    function automatic logic [1:0] pair_group(input logic [6:0] p, input logic es);
        logic [1:0] g;
        g = 2'd3;
        if (es) begin
            if (p == 7'd127) g = 2'd0;
            else if (p == 7'd126) g = 2'd1;
            else if (p == 7'd124 || p == 7'd125) g = 2'd2;
        end else begin
            if (p == 7'd0) g = 2'd0;
            else if (p == 7'd1) g = 2'd1;
            else if (p == 7'd2 || p == 7'd3) g = 2'd2;
        end
        return g;
    endfunction

    function automatic logic [1:0] fmt_field(input logic [7:0] d);
        logic [1:0] f;
        if (d[7:6] != 2'b00) f = 2'd3;
        else if (d[5]) f = 2'd2;
        else if (d[4]) f = 2'd1;
        else f = 2'd0;
        return f;
    endfunction

    function automatic logic [15:0] pack_ref(input logic [15:0] ref_val,
                                             input logic [1:0] grp,
                                             input logic [5:0] fmt,
                                             input logic es);
        logic [1:0]  code;
        logic [15:0] offs;
        logic [15:0] r;
        logic [15:0] w;
        case (grp)
            2'd0:    code = fmt[1:0];
            2'd1:    code = fmt[3:2];
            2'd2:    code = fmt[5:4];
            default: code = 2'd0;
        endcase
        case (code)
            2'd3:    offs = 16'd960;
            2'd2:    offs = 16'd768;
            2'd1:    offs = 16'd512;
            default: offs = 16'd0;
        endcase
        r = ref_val;
        if (es && code != 2'd0) begin
            r = (ref_val < offs) ? 16'd0 : ref_val - offs;
        end
        case (code)
            2'd3:    w = {r[7:0], 8'd0};
            2'd2:    w = {r[9:0], 6'd0};
            2'd1:    w = {r[10:0], 5'd0};
            default: w = {r[11:0], 4'd0};
        endcase
        return w;
    endfunction

    logic [15:0]    r_rv;
    logic [LCW-1:0] r_lc;
    logic [15:0]    r_even;
    logic [7:0]     r_maxd [3];
    logic [5:0]     r_fmt;
    logic           r_es;
    logic [1:0]     r_ch;
    logic           r_pass;
    logic [2:0]     r_inc;

    logic           r_ovalid;
    logic           r_okind;
    logic [15:0]    r_oword;
    logic [6:0]     r_opair;
    logic           r_olast;

    logic [7:0]     w_rdata;
    logic [5:0]     w_raddr;
    logic [LCW-1:0] w_lc_inc;
    logic [15:0]    w_rv_n;
    logic [1:0]     w_lsb;
    logic [15:0]    w_lvl;
    logic [15:0]    w_adiff;
    logic [7:0]     w_diff;
    logic [6:0]     w_pair;
    logic           w_es_eff;
    logic [1:0]     w_grp;
    logic [5:0]     w_fmt_n;
    logic           w_odd;
    logic           w_emit;
    logic           w_out_full;

    assign w_lc_inc = r_lc + 1'b1;
    // address the store for the level that comes up next cycle
    assign w_raddr  = i_ctl.step ? w_lc_inc[7:2] : r_lc[7:2];

    gtup_ram #(
        .WIDTH (8),
        .DEPTH (64)
    ) u_lsb_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.load),
        .i_waddr (i_lsb_index),
        .i_wdata (i_data_byte),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rv_n  = r_rv + {13'd0, r_inc};
    assign w_lsb   = w_rdata[{r_lc[1:0], 1'b0} +: 2];
    assign w_lvl   = {w_rv_n[13:0], w_lsb};
    assign w_adiff = (w_lvl > r_even) ? (w_lvl - r_even) : (r_even - w_lvl);
    assign w_diff  = w_adiff[7:0];
    assign w_pair  = r_lc[7:1];
    assign w_odd   = r_lc[0];
    // in the measuring pass, pair zero of channel zero picks the end select before grouping
    assign w_es_eff = (!r_pass && w_pair == 7'd0 && r_ch == 2'd0) ? (w_diff <= 8'd15)
                                                                  : r_es;
    assign w_grp   = pair_group(w_pair, w_es_eff);
    assign w_fmt_n = {fmt_field(r_maxd[2]), fmt_field(r_maxd[1]), fmt_field(r_maxd[0])};
    assign w_emit  = (i_ctl.step && w_odd && r_pass) || i_ctl.fmt;

    assign w_out_full     = r_ovalid && !i_m_tready;
    assign o_sts.lc_done  = r_lc[LCW-1];
    assign o_sts.out_full = w_out_full;
    assign o_sts.pass1    = r_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv     <= '0;
            r_lc     <= '0;
            r_even   <= '0;
            r_maxd   <= '{default: '0};
            r_fmt    <= '0;
            r_es     <= 1'b0;
            r_ch     <= '0;
            r_pass   <= 1'b0;
            r_inc    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_ctl.start) begin
                r_ch   <= i_channel;
                r_pass <= i_pass_number;
                r_rv   <= '0;
                r_lc   <= '0;
            end
            if (i_ctl.arm) begin
                r_inc <= i_data_byte[7:5];
            end
            if (i_ctl.step) begin
                r_rv <= w_rv_n;
                r_lc <= w_lc_inc;
                if (!w_odd) begin
                    r_even <= w_lvl;
                end else if (!r_pass) begin
                    r_es <= w_es_eff;
                    for (int i = 0; i < 3; i++) begin
                        if (w_grp == i[1:0] && w_diff > r_maxd[i]) begin
                            r_maxd[i] <= w_diff;
                        end
                    end
                end
            end
            if (i_ctl.fmt) begin
                r_fmt <= w_fmt_n;
            end
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.fmt) begin
            r_okind <= KIND_FORMAT;
            r_oword <= {9'd0, r_es, w_fmt_n};
            r_opair <= '0;
            r_olast <= 1'b1;
        end else if (w_emit) begin
            r_okind <= KIND_PACKED;
            r_oword <= pack_ref(r_even, w_grp, r_fmt, r_es) | {8'd0, w_diff};
            r_opair <= w_pair;
            r_olast <= i_ctl.tail || (r_lc[7:0] == 8'hff);
        end
    end

    assign o_valid      = r_ovalid;
    assign o_kind       = r_okind;
    assign o_word       = r_oword;
    assign o_pair_index = r_opair;
    assign o_last       = r_olast;

endmodule
